@@ rtl/core/bbfe_pkg.sv @@
package bbfe_pkg;

   localparam int MAX_LEN_DEFAULT = 1024;

   localparam int BYTE_W  = 8;
   localparam int SLOT_W  = 10;
   localparam int EVENT_W = 2;
   localparam int TAG_W   = 3;

   // Balance is never stored below zero, so it is kept unsigned and saturates at all ones.
   localparam int BAL_W = 10;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-3:0] REG_SOURCE_TAG = '0;

   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h7b;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h7d;

   typedef enum logic [1:0] {
      CLASS_OTHER,
      CLASS_OPEN,
      CLASS_CLOSE
   } brace_class_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_DATA   = 2'd0,
      EV_DONE   = 2'd1,
      EV_REJECT = 2'd2,
      EV_ERROR  = 2'd3
   } event_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      brace_class_type   brace_class;
   } queue_item_type;

endpackage

@@ rtl/core/bbfe_if.sv @@
interface bbfe_req_if;
   import bbfe_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface bbfe_rsp_if;
   import bbfe_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic [SLOT_W-1:0]  slot;
   logic [EVENT_W-1:0] event_res;
   logic [TAG_W-1:0]   frame_tag;

   modport source (output valid, output out_byte, output slot, output event_res,
                   output frame_tag, input ready);
   modport sink (input valid, input out_byte, input slot, input event_res,
                 input frame_tag, output ready);
endinterface

@@ rtl/core/bbfe_front.sv @@
module bbfe_front (
   input  logic                    clock,
   input  logic                    reset,
   bbfe_req_if.sink                req_bus,
   output logic                    push_valid,
   input  logic                    push_ready,
   output bbfe_pkg::queue_item_type push_item
);
   import bbfe_pkg::*;

   logic           front_valid_ff;
   logic           front_valid_in;
   queue_item_type front_item_ff;
   queue_item_type front_item_in;
   logic           req_fire;
   logic           is_space;
   brace_class_type byte_class;

   assign req_bus.ready = !front_valid_ff || push_ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign push_valid    = front_valid_ff;
   assign push_item     = front_item_ff;

   always_comb begin
      is_space = (req_bus.data_byte == CHAR_TAB) || (req_bus.data_byte == CHAR_CR) ||
                 (req_bus.data_byte == CHAR_LF);
      unique case (req_bus.data_byte)
         CHAR_OPEN:  byte_class = CLASS_OPEN;
         CHAR_CLOSE: byte_class = CLASS_CLOSE;
         default:    byte_class = CLASS_OTHER;
      endcase
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      front_item_in  = front_item_ff;
      if (req_fire) begin
         front_valid_in          = !is_space;
         front_item_in.data_byte = req_bus.data_byte;
         front_item_in.brace_class = byte_class;
      end else if (push_valid && push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_item_ff <= front_item_in;
   end

endmodule

@@ rtl/core/bbfe_queue.sv @@
module bbfe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  bbfe_pkg::queue_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output bbfe_pkg::queue_item_type pop_item
);
   import bbfe_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   queue_item_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/bbfe_back.sv @@
module bbfe_back #(
   parameter int MAX_LEN = bbfe_pkg::MAX_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  bbfe_pkg::queue_item_type     pop_item,
   input  logic [bbfe_pkg::TAG_W-1:0]   source_tag,
   bbfe_rsp_if.source                   rsp_bus
);
   import bbfe_pkg::*;

   localparam int POS_W = $clog2(MAX_LEN - 1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LEN - 2);
   localparam logic [BAL_W-1:0] BAL_MAX  = '1;

   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic [BAL_W-1:0]   bal_ff;
   logic [BAL_W-1:0]   bal_in;
   logic               open_seen_ff;
   logic               open_seen_in;
   logic               start_open_ff;
   logic               start_open_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  slot_in;
   event_type          event_ff;
   event_type          event_in;
   logic [TAG_W-1:0]   tag_ff;
   logic [TAG_W-1:0]   tag_in;

   logic               pop;
   logic               is_open;
   logic               is_close;
   logic               brace_error;
   logic               frame_end;
   logic [BAL_W-1:0]   bal_step;
   logic               open_seen_step;
   logic               start_open_step;
   logic [POS_W+SLOT_W-1:0] pos_wide;

   assign pop_ready         = !rsp_valid_ff || rsp_bus.ready;
   assign pop               = pop_valid && pop_ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_byte  = out_byte_ff;
   assign rsp_bus.slot      = slot_ff;
   assign rsp_bus.event_res = event_ff;
   assign rsp_bus.frame_tag = tag_ff;

   always_comb begin
      is_open  = (pop_item.brace_class == CLASS_OPEN);
      is_close = (pop_item.brace_class == CLASS_CLOSE);
      pos_wide = {{SLOT_W{1'b0}}, pos_ff};
      slot_in  = pos_wide[SLOT_W-1:0];

      bal_step = bal_ff;
      if (is_open && (bal_ff != BAL_MAX)) begin
         bal_step = bal_ff + BAL_W'(1);
      end else if (is_close) begin
         bal_step = bal_ff - BAL_W'(1);
      end
      brace_error     = is_close && (bal_ff == '0);
      open_seen_step  = open_seen_ff || is_open;
      start_open_step = (pos_ff == '0) ? is_open : start_open_ff;
      frame_end       = !brace_error && (bal_step == '0) && open_seen_step;

      event_in = EV_DATA;
      tag_in   = '0;
      if (brace_error) begin
         event_in = EV_ERROR;
      end else if (frame_end) begin
         if (start_open_step) begin
            event_in = EV_DONE;
            tag_in   = source_tag;
         end else begin
            event_in = EV_REJECT;
         end
      end

      if (brace_error || frame_end) begin
         pos_in        = '0;
         bal_in        = '0;
         open_seen_in  = 1'b0;
         start_open_in = 1'b0;
      end else begin
         pos_in        = (pos_ff < POS_LAST) ? pos_ff + POS_W'(1) : pos_ff;
         bal_in        = bal_step;
         open_seen_in  = open_seen_step;
         start_open_in = start_open_step;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         bal_ff        <= '0;
         open_seen_ff  <= 1'b0;
         start_open_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            pos_ff        <= pos_in;
            bal_ff        <= bal_in;
            open_seen_ff  <= open_seen_in;
            start_open_ff <= start_open_in;
         end
      end
      if (pop) begin
         out_byte_ff <= pop_item.data_byte;
         slot_ff     <= slot_in;
         event_ff    <= event_in;
         tag_ff      <= tag_in;
      end
   end

`ifndef ASSERT_OFF
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("Write position passed the last slot.");

   a_bal_needs_open: assert property (@(posedge clock) disable iff (reset)
      !open_seen_ff |-> (bal_ff == '0))
      else $error("Brace balance is nonzero with no open brace seen.");

   a_tag_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (event_ff != EV_DONE) |-> (tag_ff == '0))
      else $error("Frame tag is set on a request that does not complete a frame.");

   a_clear_on_end: assert property (@(posedge clock) disable iff (reset)
      pop && (event_in != EV_DATA) |=> (pos_ff == '0) && (bal_ff == '0) && !open_seen_ff)
      else $error("Framing state was not cleared after a frame ended.");
`endif

endmodule

@@ rtl/core/brace_balanced_frame_extractor_core.sv @@
// Channel   Direction  Payload                                   Handshake
// req_bus   in         data_byte[7:0]                            valid/ready
// rsp_bus   out        out_byte[7:0] slot[9:0] event_res[1:0]    valid/ready
//                      frame_tag[2:0]
// csr       in         source_tag at byte address 0              APB, pready high
//
// A request is taken every cycle unless the result side stalls; its result passes in turn through
// the front register, the queue and the output register.
// Tab, CR and LF requests are taken and give no result.
// Reset is synchronous and clears all framing state and the source tag.
// Either side may stall; the two-entry queue and the output register hold requests meanwhile.
module brace_balanced_frame_extractor_core #(
   parameter int MAX_LEN = bbfe_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   bbfe_req_if.sink                            req_bus,
   bbfe_rsp_if.source                          rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bbfe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bbfe_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bbfe_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import bbfe_pkg::*;

   logic [TAG_W-1:0] source_tag_ff;
   logic [TAG_W-1:0] source_tag_in;
   logic             reg_hit;
   logic             push_valid;
   logic             push_ready;
   queue_item_type   push_item;
   logic             pop_valid;
   logic             pop_ready;
   queue_item_type   pop_item;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[CSR_ADDR_W-1:2] == REG_SOURCE_TAG);

   always_comb begin
      source_tag_in = source_tag_ff;
      if (psel && penable && pwrite && reg_hit) begin
         source_tag_in = pwdata[TAG_W-1:0];
      end
      prdata = reg_hit ? {{(CSR_DATA_W - TAG_W){1'b0}}, source_tag_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_tag_ff <= '0;
      end else begin
         source_tag_ff <= source_tag_in;
      end
   end

   bbfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   bbfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   bbfe_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .source_tag (source_tag_ff),
      .rsp_bus    (rsp_bus)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import bbfe_pkg::*;

   localparam int FRAME_LAST_SLOT = MAX_LEN_DEFAULT - 2;
   localparam int DEPTH_LIMIT = 2 ** BAL_W - 1;
   localparam int MAX_GAP = 12;
   localparam int DIRECTED_COUNT = 26;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_BYTES = 95;
   localparam int DRAIN_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_ADDR_W-1:0] SOURCE_TAG_ADDR = {REG_SOURCE_TAG, 2'b00};

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [SLOT_W-1:0] slot;
      event_type         event_res;
      logic [TAG_W-1:0]  frame_tag;
   } frame_result_type;

   typedef struct {
      logic [BYTE_W-1:0] b;
      bit                typed;
      logic [SLOT_W-1:0] slot;
      event_type         ev;
      logic [TAG_W-1:0]  tag;
   } stim_row_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   bbfe_req_if req_bus ();
   bbfe_rsp_if rsp_bus ();

   brace_balanced_frame_extractor_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Framing state as the block should hold it.
   logic [SLOT_W-1:0] frame_pos = '0;
   int                brace_depth = 0;
   bit                opened = 1'b0;
   bit                led_by_open = 1'b0;
   logic [TAG_W-1:0]  source_tag_cfg = '0;

   frame_result_type  pending_results[$];
   frame_result_type  expected_head;
   logic [BYTE_W-1:0] burst[$];
   int                check_failures = 0;
   int                phase_bytes = 0;
   bit                idling_on = 1'b1;

   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{8'h7b, 1'b1, 10'd0, EV_DATA,   3'd0},
      '{8'h7d, 1'b1, 10'd1, EV_DONE,   3'd0},
      '{8'h09, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h0d, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h0a, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7d, 1'b1, 10'd0, EV_ERROR,  3'd0},
      '{8'h61, 1'b1, 10'd0, EV_DATA,   3'd0},
      '{8'h7b, 1'b1, 10'd1, EV_DATA,   3'd0},
      '{8'h09, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7d, 1'b1, 10'd2, EV_REJECT, 3'd0},
      '{8'h00, 1'b1, 10'd0, EV_DATA,   3'd0},
      '{8'hff, 1'b1, 10'd1, EV_DATA,   3'd0},
      '{8'h7d, 1'b1, 10'd2, EV_ERROR,  3'd0},
      '{8'h7b, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7b, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7c, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7d, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h0a, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7d, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h08, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h0b, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h0c, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7a, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7e, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7b, 1'b0, 10'd0, EV_DATA,   3'd0},
      '{8'h7d, 1'b0, 10'd0, EV_DATA,   3'd0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic bit is_blank(input logic [BYTE_W-1:0] b);
      return b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF;
   endfunction

   function automatic int draw_gap();
      return idling_on ? $urandom_range(0, MAX_GAP) : 0;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_blank();
      case ($urandom_range(0, 2))
         0: return CHAR_TAB;
         1: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_filler();
      logic [BYTE_W-1:0] b;
      case ($urandom_range(0, 9))
         0: b = pick_blank();
         1, 2: b = 8'($urandom_range(0, 255));
         default: b = 8'($urandom_range(8'h20, 8'h7e));
      endcase
      if (b == CHAR_OPEN || b == CHAR_CLOSE) begin
         b = 8'h2c;
      end
      return b;
   endfunction

   task automatic restart_frame();
      frame_pos = '0;
      brace_depth = 0;
      opened = 1'b0;
      led_by_open = 1'b0;
   endtask

   task automatic predict_frame_byte(input logic [BYTE_W-1:0] b, output bit emits,
                                     output frame_result_type r);
      r = '0;
      emits = 1'b0;
      if (is_blank(b)) begin
         return;
      end
      emits = 1'b1;
      r.out_byte = b;
      r.slot = frame_pos;
      r.event_res = EV_DATA;
      if (frame_pos == '0) begin
         led_by_open = (b == CHAR_OPEN);
      end
      if (b == CHAR_OPEN) begin
         opened = 1'b1;
         if (brace_depth < DEPTH_LIMIT) begin
            brace_depth++;
         end
      end else if (b == CHAR_CLOSE) begin
         brace_depth--;
      end
      if (frame_pos < FRAME_LAST_SLOT) begin
         frame_pos++;
      end
      if (brace_depth == 0 && opened) begin
         r.event_res = led_by_open ? EV_DONE : EV_REJECT;
         r.frame_tag = led_by_open ? source_tag_cfg : '0;
         restart_frame();
      end else if (brace_depth < 0) begin
         r.event_res = EV_ERROR;
         restart_frame();
      end
   endtask

   task automatic send_request(input logic [BYTE_W-1:0] b, input bit typed,
                               input frame_result_type typed_res);
      int gap;
      bit emits;
      frame_result_type r;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      predict_frame_byte(b, emits, r);
      if (emits) begin
         pending_results.push_back(typed ? typed_res : r);
      end
   endtask

   task automatic send_burst();
      foreach (burst[i]) begin
         send_request(burst[i], 1'b0, '0);
         if (!is_blank(burst[i])) begin
            phase_bytes++;
         end
      end
      burst.delete();
   endtask

   task automatic add_object();
      int depth;
      int max_depth;
      int steps;
      int r;
      max_depth = $urandom_range(1, 6);
      steps = $urandom_range(0, 20);
      burst.push_back(CHAR_OPEN);
      depth = 1;
      repeat (steps) begin
         r = $urandom_range(0, 9);
         if (r < 2 && depth < max_depth) begin
            burst.push_back(CHAR_OPEN);
            depth++;
         end else if (r < 4 && depth > 1) begin
            burst.push_back(CHAR_CLOSE);
            depth--;
         end else begin
            burst.push_back(pick_filler());
         end
      end
      repeat (depth) burst.push_back(CHAR_CLOSE);
   endtask

   task automatic add_random_sequence();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         if (kind < 10) begin
            burst.push_back(pick_blank());
         end
         add_object();
      end else if (kind < 70) begin
         repeat ($urandom_range(1, 4)) burst.push_back(pick_filler());
         add_object();
      end else if (kind < 80) begin
         repeat ($urandom_range(0, 5)) burst.push_back(pick_filler());
         burst.push_back(CHAR_CLOSE);
      end else if (kind < 92) begin
         repeat ($urandom_range(1, 8)) burst.push_back(8'($urandom_range(0, 255)));
      end else begin
         add_object();
         burst.push_back(CHAR_CLOSE);
      end
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= SOURCE_TAG_ADDR;
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_source_tag_readback();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(source_tag_cfg)) begin
         $error("source_tag readback: expected %0h, got %0h", source_tag_cfg, rd);
         check_failures++;
      end
   endtask

   task automatic program_source_tag(input logic [TAG_W-1:0] tag);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, {$urandom} & ~CSR_DATA_W'(7) | CSR_DATA_W'(tag), rd);
      source_tag_cfg = tag;
      check_source_tag_readback();
   endtask

   task automatic settle_pipeline();
      int cycles;
      cycles = 0;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0 && cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      wait (!reset);
      forever begin
         int gap;
         gap = draw_gap();
         if (gap > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("out_byte: expected no result, got %0h", rsp_bus.out_byte);
            check_failures++;
         end else begin
            expected_head = pending_results.pop_front();
            if (rsp_bus.out_byte !== expected_head.out_byte) begin
               $error("out_byte: expected %0h, got %0h", expected_head.out_byte,
                      rsp_bus.out_byte);
               check_failures++;
            end
            if (rsp_bus.slot !== expected_head.slot) begin
               $error("slot: expected %0d, got %0d", expected_head.slot, rsp_bus.slot);
               check_failures++;
            end
            if (rsp_bus.event_res !== expected_head.event_res) begin
               $error("event_res: expected %0d, got %0d", expected_head.event_res,
                      rsp_bus.event_res);
               check_failures++;
            end
            if (rsp_bus.frame_tag !== expected_head.frame_tag) begin
               $error("frame_tag: expected %0d, got %0d", expected_head.frame_tag,
                      rsp_bus.frame_tag);
               check_failures++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_source_tag_readback();
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].b, directed_rows[i].typed,
                      '{directed_rows[i].b, directed_rows[i].slot,
                        directed_rows[i].ev, directed_rows[i].tag});
      end
      settle_pipeline();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         idling_on = (phase % 3 != 2);
         if (phase == 0) begin
            program_source_tag(3'd7);
         end else if (phase == 1) begin
            program_source_tag(3'd0);
         end else begin
            program_source_tag(3'($urandom_range(0, 7)));
         end
         phase_bytes = 0;
         // Nesting deeper than the balance counter holds, which also fills the buffer.
         if (phase == PHASE_COUNT - 1) begin
            repeat (DEPTH_LIMIT + 7) burst.push_back(CHAR_OPEN);
            send_burst();
         end
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            add_random_sequence();
            send_burst();
         end
         settle_pipeline();
      end

      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         check_failures++;
      end
      if (check_failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
